// ===== design/indirect_coefficient_ram_port_core_assert.svh =====
// ----------------------------------------------------------------------------
// indirect_coefficient_ram_port_core_assert.svh
// assertion macros used by the coefficient ram port sequencer
// ----------------------------------------------------------------------------
`ifndef INDIRECT_COEFFICIENT_RAM_PORT_CORE_ASSERT_SVH
`define INDIRECT_COEFFICIENT_RAM_PORT_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define ICRP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icrp: same-cycle check failed");

// next-cycle implication, off during reset
`define ICRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icrp: next-cycle check failed");

`endif

// ===== design/icrp_pkg.sv =====
// ----------------------------------------------------------------------------
// icrp_pkg
// constants, register map and controller/datapath interface types
// ----------------------------------------------------------------------------
package icrp_pkg;

  // storage sizes; ram depth is a power of two
  localparam int RAM_DEPTH   = 1024;
  localparam int WORD_BITS   = 24;
  localparam int BLOCK_WORDS = 5;

  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int ADDR_BITS = 10;
  localparam int SIDX_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

  // register window
  localparam logic [7:0] WIN_ADDR_HI     = 8'h3B;
  localparam logic [7:0] WIN_ADDR_LO     = 8'h3C;
  localparam logic [7:0] WIN_STAGE_FIRST = 8'h3D;
  localparam logic [7:0] WIN_RAM_LAST    = 8'h3F;
  localparam logic [7:0] WIN_STAGE_LAST  = 8'h4B;
  localparam logic [7:0] WIN_CMD         = 8'h4C;

  localparam logic [7:0] CMD_WRITE_ONE = 8'h01;
  localparam logic [7:0] CMD_WRITE_ALL = 8'h02;
  localparam logic [7:0] ADDR_HI_MASK  = 8'h03;

  localparam logic FUNC_WRITE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic              load;     // capture accepted word
    logic              exec;     // apply register writes
    logic              ram_re;
    logic              ram_we;
    logic              clear;    // ram clearing pass
    logic [SIDX_W-1:0] idx;      // store step
    logic [RAM_AW-1:0] clr_idx;
    logic              out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_ram_rd;
    logic is_store;
    logic store_all;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== design/indirect_coefficient_ram_port_core.sv =====
// sequence: an accepted word is decoded; address, staging and command words then go to the
// result step, a ram byte read waits on the registered ram read first, and a store writes
// one word (write-one) or BLOCK_WORDS words (write-all); one access at a time, and the next
// word is taken the cycle after the result is loaded, even while it waits on out_ready
// reset: synchronous; a clearing pass after reset zeroes the ram, with in_ready
// low throughout
// ----------------------------------------------------------------------------
// indirect_coefficient_ram_port_core
// byte register window 0x3B..0x4C giving indirect access to a coefficient ram
// ----------------------------------------------------------------------------
module indirect_coefficient_ram_port_core (
  input  logic       clk,
  input  logic       rst,

  // access word in
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] reg_addr,
  input  logic [7:0] wdata,

  // result word out
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] rdata
);

  // command and status between sequencer and datapath
  icrp_pkg::ctrl_cmd_t cmd;
  icrp_pkg::dp_sts_t   sts;

  // sequencer: clearing pass, decode step, store loop, result hand-off
  icrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: window registers, staging words, ram and the output register
  // that parts the result side from the access side
  icrp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .reg_addr  (reg_addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (rdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/icrp_ram.sv =====
// ----------------------------------------------------------------------------
// icrp_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module icrp_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/icrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// icrp_ctrl
// sequencer: ram clear after reset, access decode, block store, result hand-off
// ----------------------------------------------------------------------------
`include "indirect_coefficient_ram_port_core_assert.svh"

module icrp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  icrp_pkg::dp_sts_t   sts,
  output icrp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_STORE,
    S_DONE
  } state_t;

  state_t                      state;
  logic [icrp_pkg::SIDX_W-1:0] cnt;
  logic [icrp_pkg::RAM_AW-1:0] clr_idx;
  logic [icrp_pkg::SIDX_W-1:0] last;

  assign last = sts.store_all ? icrp_pkg::SIDX_W'(icrp_pkg::BLOCK_WORDS - 1) : '0;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.ram_re   = (state == S_EXEC) && sts.is_ram_rd;
    cmd.ram_we   = (state == S_STORE) || (state == S_CLEAR);
    cmd.clear    = (state == S_CLEAR);
    cmd.idx      = cnt;
    cmd.clr_idx  = clr_idx;
    cmd.out_load = (state == S_DONE) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      clr_idx <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == icrp_pkg::RAM_AW'(icrp_pkg::RAM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts.is_ram_rd) begin
            state <= S_RD_WAIT;
          end else if (sts.is_store) begin
            state <= S_STORE;
          end else begin
            state <= S_DONE;
          end
        end
        S_RD_WAIT: begin
          state <= S_DONE;
        end
        S_STORE: begin
          if (cnt == last) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ICRP_ASSERT_NOW(a_no_rw_clash, clk, rst, cmd.ram_we, !cmd.ram_re)
  `ICRP_ASSERT_NOW(a_load_when_free, clk, rst, cmd.out_load, !sts.out_busy)
  `ICRP_ASSERT_NEXT(a_accept_to_exec, clk, rst, in_valid && in_ready, state == S_EXEC)
  `ICRP_ASSERT_NOW(a_store_bound, clk, rst, state == S_STORE,
                   cnt <= icrp_pkg::SIDX_W'(icrp_pkg::BLOCK_WORDS - 1))

endmodule

// ===== design/icrp_dp.sv =====
// ----------------------------------------------------------------------------
// icrp_dp
// datapath: access word capture, address and staging registers, coefficient
// ram, read-back mux and output register
// ----------------------------------------------------------------------------
module icrp_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                func,
  input  logic [7:0]          reg_addr,
  input  logic [7:0]          wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          rdata,
  input  icrp_pkg::ctrl_cmd_t cmd,
  output icrp_pkg::dp_sts_t   sts
);

  // divide-by-3 of a 4-bit offset via reciprocal multiply
  localparam logic [7:0] DIV3_MUL = 8'd11;
  localparam int         DIV3_SH  = 5;

  logic                             func_q;
  logic [7:0]                       addr_q;
  logic [7:0]                       wdata_q;
  logic [icrp_pkg::ADDR_BITS-1:0]   ram_addr;
  logic [23:0]                      staged [icrp_pkg::BLOCK_WORDS];

  logic [7:0]                       off;
  logic [7:0]                       prod;
  logic [2:0]                       k;
  logic [3:0]                       rem;
  logic [1:0]                       pos;
  logic                             k_ok;
  logic                             in_stage;
  logic                             in_ram;
  logic [icrp_pkg::SIDX_W-1:0]      st_idx;
  logic [23:0]                      st_word;
  logic [31:0]                      st_word32;
  logic [icrp_pkg::ADDR_BITS-1:0]   addr_sum;
  logic [icrp_pkg::RAM_AW-1:0]      ram_idx;
  logic [icrp_pkg::WORD_BITS-1:0]   ram_wdata;
  logic [icrp_pkg::WORD_BITS-1:0]   ram_rdata;
  logic [31:0]                      ram_word32;
  logic [7:0]                       result;

  function automatic logic [7:0] byte_of(logic [23:0] w, logic [1:0] p);
    logic [7:0] b;
    case (p)
      2'd0:    b = w[23:16];
      2'd1:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // window decode of the captured word
  assign off      = addr_q - icrp_pkg::WIN_STAGE_FIRST;
  assign prod     = {4'b0, off[3:0]} * DIV3_MUL;
  assign k        = prod[DIV3_SH +: 3];
  assign rem      = off[3:0] - {k, 1'b0} - {1'b0, k};
  assign pos      = rem[1:0];
  assign k_ok     = int'(k) < icrp_pkg::BLOCK_WORDS;
  assign in_stage = (addr_q >= icrp_pkg::WIN_STAGE_FIRST)
                 && (addr_q <= icrp_pkg::WIN_STAGE_LAST);
  assign in_ram   = (addr_q >= icrp_pkg::WIN_STAGE_FIRST)
                 && (addr_q <= icrp_pkg::WIN_RAM_LAST);

  // one staging read port, shared by block store and read-back
  assign st_idx    = cmd.ram_we ? cmd.idx : icrp_pkg::SIDX_W'(k);
  assign st_word   = staged[st_idx];
  assign st_word32 = {8'b0, st_word};

  assign addr_sum  = ram_addr + icrp_pkg::ADDR_BITS'(cmd.idx);
  assign ram_idx   = cmd.clear ? cmd.clr_idx : addr_sum[icrp_pkg::RAM_AW-1:0];
  assign ram_wdata = cmd.clear ? '0 : st_word32[icrp_pkg::WORD_BITS-1:0];

  icrp_ram #(
    .WIDTH (icrp_pkg::WORD_BITS),
    .DEPTH (icrp_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .re    (cmd.ram_re),
    .addr  (ram_idx),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ram_word32 = 32'(ram_rdata);

  always_comb begin
    result = '0;
    if (func_q != icrp_pkg::FUNC_WRITE) begin
      if (addr_q == icrp_pkg::WIN_ADDR_HI) begin
        result = {6'b0, ram_addr[9:8]};
      end else if (addr_q == icrp_pkg::WIN_ADDR_LO) begin
        result = ram_addr[7:0];
      end else if (in_ram) begin
        result = byte_of(ram_word32[23:0], pos);
      end else if (in_stage && k_ok) begin
        result = byte_of(st_word, pos);
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.is_ram_rd = (func_q != icrp_pkg::FUNC_WRITE) && in_ram;
    sts.is_store  = (func_q == icrp_pkg::FUNC_WRITE) && (addr_q == icrp_pkg::WIN_CMD)
                 && ((wdata_q == icrp_pkg::CMD_WRITE_ONE)
                  || (wdata_q == icrp_pkg::CMD_WRITE_ALL));
    sts.store_all = (wdata_q == icrp_pkg::CMD_WRITE_ALL);
    sts.out_busy  = out_valid && !out_ready;
  end

  // captured word and result byte
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      addr_q  <= reg_addr;
      wdata_q <= wdata;
    end
    if (cmd.out_load) begin
      rdata <= result;
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_addr <= '0;
      for (int i = 0; i < icrp_pkg::BLOCK_WORDS; i++) begin
        staged[i] <= '0;
      end
    end else if (cmd.exec && (func_q == icrp_pkg::FUNC_WRITE)) begin
      if (addr_q == icrp_pkg::WIN_ADDR_HI) begin
        ram_addr[9:8] <= wdata_q[1:0] & icrp_pkg::ADDR_HI_MASK[1:0];
      end else if (addr_q == icrp_pkg::WIN_ADDR_LO) begin
        ram_addr[7:0] <= wdata_q;
      end else if (in_stage && k_ok) begin
        case (pos)
          2'd0:    staged[icrp_pkg::SIDX_W'(k)][23:16] <= wdata_q;
          2'd1:    staged[icrp_pkg::SIDX_W'(k)][15:8]  <= wdata_q;
          default: staged[icrp_pkg::SIDX_W'(k)][7:0]   <= wdata_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the coefficient ram register window against an in-bench model of
// the address, staging and ram state, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb;

  localparam logic FUNC_READ = ~icrp_pkg::FUNC_WRITE;

  // cycles with no handshake on either channel before the run is abandoned;
  // covers the ram clearing pass after reset with a wide margin
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_WORDS = 700;

  // ram words only keep the staged bits that fit the word width
  localparam int KEEP_BITS = (icrp_pkg::WORD_BITS < 24) ? icrp_pkg::WORD_BITS : 24;
  localparam logic [23:0] STORE_MASK = 24'hFFFFFF >> (24 - KEEP_BITS);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = 1'b0;
  logic [7:0] reg_addr = 8'h00;
  logic [7:0] wdata = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] rdata;

  always #5 clk = ~clk;

  indirect_coefficient_ram_port_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .reg_addr  (reg_addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (rdata)
  );

  // shadow copy of the block state
  logic [icrp_pkg::ADDR_BITS-1:0] shadow_addr;
  logic [23:0]                    shadow_stage [icrp_pkg::BLOCK_WORDS];
  logic [23:0]                    shadow_ram [icrp_pkg::RAM_DEPTH];

  // read bytes still owed by the block, oldest first
  logic [7:0] pending_rdata [$];
  logic [7:0] want_rdata;

  int  fails = 0;
  int  n_reads = 0;
  int  n_writes = 0;
  int  n_checked = 0;
  int  n_store_one = 0;
  int  n_store_all = 0;
  int  n_bad_cmd = 0;
  int  n_window = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // ram index of the current address plus an offset, wrapping at the depth
  function automatic int ram_slot(int offset);
    return (int'(shadow_addr) + offset) % icrp_pkg::RAM_DEPTH;
  endfunction

  // byte pos of a word, most significant first
  function automatic logic [7:0] word_byte(logic [23:0] w, int pos);
    logic [23:0] s;
    s = w >> (16 - 8 * pos);
    return s[7:0];
  endfunction

  // applies one access word to the shadow state, returns the read byte
  function automatic logic [7:0] window_access(logic f, logic [7:0] a, logic [7:0] d);
    int         off;
    int         k;
    int         pos;
    int         i;
    logic [7:0] hi;
    logic [7:0] r;
    r = 8'h00;
    off = int'(a) - int'(icrp_pkg::WIN_STAGE_FIRST);
    k = (off >= 0) ? off / 3 : 0;
    pos = (off >= 0) ? off % 3 : 0;
    if (f == icrp_pkg::FUNC_WRITE) begin
      if (a == icrp_pkg::WIN_ADDR_HI) begin
        // only the two address bits survive
        hi = d & icrp_pkg::ADDR_HI_MASK;
        shadow_addr[icrp_pkg::ADDR_BITS-1:8] = hi[1:0];
      end else if (a == icrp_pkg::WIN_ADDR_LO) begin
        shadow_addr[7:0] = d;
      end else if (a >= icrp_pkg::WIN_STAGE_FIRST && a <= icrp_pkg::WIN_STAGE_LAST) begin
        // bytes of words past the block are dropped
        if (k < icrp_pkg::BLOCK_WORDS) shadow_stage[k][(16 - 8 * pos) +: 8] = d;
      end else if (a == icrp_pkg::WIN_CMD) begin
        if (d == icrp_pkg::CMD_WRITE_ONE) begin
          shadow_ram[ram_slot(0)] = shadow_stage[0] & STORE_MASK;
          n_store_one++;
        end else if (d == icrp_pkg::CMD_WRITE_ALL) begin
          for (i = 0; i < icrp_pkg::BLOCK_WORDS; i++)
            shadow_ram[ram_slot(i)] = shadow_stage[i] & STORE_MASK;
          n_store_all++;
        end else begin
          n_bad_cmd++;
        end
      end
    end else begin
      if (a == icrp_pkg::WIN_ADDR_HI) begin
        r = {6'b0, shadow_addr[icrp_pkg::ADDR_BITS-1:8]};
      end else if (a == icrp_pkg::WIN_ADDR_LO) begin
        r = shadow_addr[7:0];
      end else if (a >= icrp_pkg::WIN_STAGE_FIRST && a <= icrp_pkg::WIN_RAM_LAST) begin
        // first three window bytes read the ram, not staged word 0
        r = word_byte(shadow_ram[ram_slot(0)], pos);
      end else if (a > icrp_pkg::WIN_RAM_LAST && a <= icrp_pkg::WIN_STAGE_LAST
                   && k < icrp_pkg::BLOCK_WORDS) begin
        r = word_byte(shadow_stage[k], pos);
      end
    end
    return r;
  endfunction

  // every accepted access word owes exactly one result word
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_rdata.push_back(window_access(func, reg_addr, wdata));
      if (func == icrp_pkg::FUNC_WRITE) n_writes++;
      else n_reads++;
    end
  end

  // result checker, compares against the oldest owed byte
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_rdata.size() == 0) begin
        $error("rdata: result word with nothing expected, actual %02h", rdata);
        fails++;
      end else begin
        want_rdata = pending_rdata.pop_front();
        n_checked++;
        if (rdata !== want_rdata) begin
          $error("rdata mismatch: expected %02h, actual %02h", want_rdata, rdata);
          fails++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words owed",
               quiet_cycles, pending_rdata.size());
      $display("indirect_coefficient_ram_port_core test failed");
      $finish;
    end
  end

  // receiver stalls, except in the steady stretch
  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(99) >= 15);
  end

  // sends one access word; returns at the edge where it is taken
  task automatic access(input logic f, input logic [7:0] a, input logic [7:0] d);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    reg_addr = a;
    wdata = d;
    do @(posedge clk); while (!in_ready);
    if (a >= icrp_pkg::WIN_ADDR_HI && a <= icrp_pkg::WIN_CMD) n_window++;
  endtask

  task automatic put_reg(input logic [7:0] a, input logic [7:0] d);
    access(icrp_pkg::FUNC_WRITE, a, d);
  endtask

  task automatic get_reg(input logic [7:0] a);
    access(FUNC_READ, a, 8'($urandom));
  endtask

  // sender holds off until the block owes nothing
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rdata.size() != 0) @(posedge clk);
  endtask

  // ram must read zero after the clearing pass
  task automatic test_reset_state();
    get_reg(icrp_pkg::WIN_STAGE_FIRST);
    get_reg(icrp_pkg::WIN_RAM_LAST);
    get_reg(icrp_pkg::WIN_CMD);
  endtask

  // address bytes, including dropped upper bits of the high byte
  task automatic test_address_bytes();
    put_reg(icrp_pkg::WIN_ADDR_HI, 8'hFF);
    put_reg(icrp_pkg::WIN_ADDR_LO, 8'hFF);
    get_reg(icrp_pkg::WIN_ADDR_HI);
    get_reg(icrp_pkg::WIN_ADDR_LO);
  endtask

  // staged bytes read back, except the ones shadowed by the ram read
  task automatic test_staging();
    put_reg(icrp_pkg::WIN_STAGE_FIRST, 8'hFF);
    put_reg(icrp_pkg::WIN_STAGE_FIRST + 8'd1, 8'h00);
    put_reg(icrp_pkg::WIN_RAM_LAST, 8'h5A);
    put_reg(icrp_pkg::WIN_RAM_LAST + 8'd1, 8'hC3);
    put_reg(icrp_pkg::WIN_STAGE_LAST, 8'hA5);
    get_reg(icrp_pkg::WIN_STAGE_LAST);
    get_reg(icrp_pkg::WIN_RAM_LAST + 8'd1);
  endtask

  // single word store at the top ram address
  task automatic test_write_one();
    put_reg(icrp_pkg::WIN_CMD, icrp_pkg::CMD_WRITE_ONE);
    get_reg(icrp_pkg::WIN_STAGE_FIRST);
  endtask

  // block store from the last ram word wraps to the bottom
  task automatic test_write_all_wrap();
    put_reg(icrp_pkg::WIN_CMD, icrp_pkg::CMD_WRITE_ALL);
    put_reg(icrp_pkg::WIN_ADDR_HI, 8'h00);
    put_reg(icrp_pkg::WIN_ADDR_LO, 8'h03);
    get_reg(icrp_pkg::WIN_RAM_LAST);
  endtask

  // commands other than the two stores do nothing
  task automatic test_unknown_command();
    put_reg(icrp_pkg::WIN_CMD, icrp_pkg::CMD_WRITE_ONE | icrp_pkg::CMD_WRITE_ALL);
    put_reg(icrp_pkg::WIN_CMD, 8'hFF);
    get_reg(icrp_pkg::WIN_STAGE_FIRST + 8'd1);
  endtask

  // accesses just outside the window and at the bottom of the register space
  task automatic test_outside_window();
    put_reg(8'h00, 8'hFF);
    get_reg(icrp_pkg::WIN_ADDR_HI - 8'd1);
    get_reg(icrp_pkg::WIN_CMD + 8'd1);
  endtask

  // mostly well-formed program: set address, stage, store, read back; now and then the command is random
  task automatic random_program();
    logic [icrp_pkg::ADDR_BITS-1:0] base;
    logic [icrp_pkg::ADDR_BITS-1:0] slot;
    logic [7:0]                     hi;
    int                             n;
    int                             i;
    int                             j;
    base = icrp_pkg::ADDR_BITS'($urandom);
    // bias toward the top of the ram so block stores wrap
    if ($urandom_range(3) == 0)
      base = icrp_pkg::ADDR_BITS'(icrp_pkg::RAM_DEPTH - 1 - $urandom_range(4));
    hi = rnd8();
    hi[1:0] = base[icrp_pkg::ADDR_BITS-1:8];
    put_reg(icrp_pkg::WIN_ADDR_HI, hi);
    put_reg(icrp_pkg::WIN_ADDR_LO, base[7:0]);
    n = $urandom_range(1, 15);
    repeat (n) put_reg(8'(icrp_pkg::WIN_STAGE_FIRST + $urandom_range(14)), rnd8());
    j = $urandom_range(9);
    if (j < 6) put_reg(icrp_pkg::WIN_CMD, icrp_pkg::CMD_WRITE_ALL);
    else if (j < 9) put_reg(icrp_pkg::WIN_CMD, icrp_pkg::CMD_WRITE_ONE);
    else put_reg(icrp_pkg::WIN_CMD, rnd8());
    n = $urandom_range(0, icrp_pkg::BLOCK_WORDS);
    for (i = 0; i < n; i++) begin
      slot = base + icrp_pkg::ADDR_BITS'(i);
      hi = rnd8();
      hi[1:0] = slot[icrp_pkg::ADDR_BITS-1:8];
      put_reg(icrp_pkg::WIN_ADDR_HI, hi);
      put_reg(icrp_pkg::WIN_ADDR_LO, slot[7:0]);
      for (j = 0; j < 3; j++) get_reg(icrp_pkg::WIN_STAGE_FIRST + 8'(j));
      if ($urandom_range(3) == 0)
        get_reg(8'(icrp_pkg::WIN_RAM_LAST + 1 + $urandom_range(11)));
    end
  endtask

  // mostly programs, some window noise and some fully random words
  task automatic test_random_traffic();
    int start;
    int pick;
    start = n_window;
    while (n_window - start < RANDOM_WORDS) begin
      steady = (n_window - start >= 250) && (n_window - start < 380);
      pick = $urandom_range(99);
      if (pick < 65) random_program();
      else if (pick < 90)
        access(1'($urandom_range(1)), 8'(icrp_pkg::WIN_ADDR_HI + $urandom_range(17)),
               rnd8());
      else access(1'($urandom_range(1)), rnd8(), rnd8());
      if ($urandom_range(19) == 0) drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin : main
    int i;
    shadow_addr = '0;
    for (i = 0; i < icrp_pkg::BLOCK_WORDS; i++) shadow_stage[i] = '0;
    for (i = 0; i < icrp_pkg::RAM_DEPTH; i++) shadow_ram[i] = '0;

    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_address_bytes();
    test_staging();
    test_write_one();
    test_write_all_wrap();
    test_unknown_command();
    test_outside_window();
    drain_results();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);

    $display("run covered %0d reads and %0d writes, %0d result words checked",
             n_reads, n_writes, n_checked);
    $display("ram stores: %0d single, %0d block, %0d ignored commands",
             n_store_one, n_store_all, n_bad_cmd);
    if (fails == 0) begin
      $display("indirect_coefficient_ram_port_core test passed");
    end else begin
      $display("indirect_coefficient_ram_port_core test failed");
    end
    $finish;
  end

endmodule
